// ===== rtl/ipd_pkg.sv =====
package ipd_pkg;

    // Field widths
    localparam int OPCODE_W = 2;
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 3;
    localparam int DLEN_W   = 16;
    localparam int ID_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int CAP_W      = 16;

    // Request opcodes
    localparam logic [OPCODE_W-1:0] OP_BYTE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_TICK = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_ARM  = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] RK_BYTE    = 3'd0;
    localparam logic [KIND_W-1:0] RK_BAD_ID  = 3'd1;
    localparam logic [KIND_W-1:0] RK_BAD_LEN = 3'd2;
    localparam logic [KIND_W-1:0] RK_HDR_TO  = 3'd3;
    localparam logic [KIND_W-1:0] RK_PAY_TO  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_TO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAY_TO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP    = 2'd2;

    // Configuration reset values
    localparam logic [CFG_DATA_W-1:0] HDR_TO_RST = 32'd1000;
    localparam logic [CFG_DATA_W-1:0] PAY_TO_RST = 32'd3000;
    localparam logic [CAP_W-1:0]      CAP_RST    = 16'd2048;

    // Header pattern "+IPD,"
    localparam logic [2:0] HDR_LEN = 3'd5;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [ID_W-1:0]   MAX_ID   = 3'd4;

    function automatic logic [BYTE_W-1:0] hdr_char(input logic [2:0] pos);
        logic [BYTE_W-1:0] c;
        case (pos)
            3'd0:    c = CH_PLUS;
            3'd1:    c = 8'h49;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h44;
            3'd4:    c = CH_COMMA;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/ipd_rx_if.sv =====
interface ipd_rx_if import ipd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [BYTE_W-1:0]   rx_byte;

    modport source (output valid, opcode, rx_byte, input ready);
    modport sink   (input valid, opcode, rx_byte, output ready);
endinterface

// ===== rtl/ipd_res_if.sv =====
interface ipd_res_if import ipd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] result_kind;
    logic [BYTE_W-1:0] payload_byte;
    logic              is_last;
    logic [DLEN_W-1:0] declared_length;
    logic [ID_W-1:0]   conn_id;
    logic              has_id;

    modport source (output valid, result_kind, payload_byte, is_last, declared_length,
                    conn_id, has_id, input ready);
    modport sink   (input valid, result_kind, payload_byte, is_last, declared_length,
                    conn_id, has_id, output ready);
endinterface

// ===== rtl/ipd_frame_deframer.sv =====
// A result is registered: it appears on o_res in the cycle after the request that causes it is taken.
// Throughput: one request per cycle; the single result register is refilled in
// the same cycle it is taken, so i_rx stalls only while a result waits unread.
// Reset (i_rst_n low, synchronous): phase idle, no result pending, registers
// back to 1000 / 3000 / 2048.
module ipd_frame_deframer import ipd_pkg::*; #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ipd_rx_if.sink                i_rx,
    ipd_res_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int FW = LENGTH_BITS;
    localparam int CW = (LENGTH_BITS > CAP_W) ? LENGTH_BITS : CAP_W;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HUNT,
        PH_HEAD,
        PH_DATA,
        PH_SKIP
    } t_phase;

    // Saturating decimal accumulate: acc * 10 + d
    function automatic logic [FW-1:0] add_digit(input logic [FW-1:0] acc,
                                                input logic [3:0] d);
        logic [FW+3:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{FW{1'b0}}, d};
        if (v > {4'b0000, {FW{1'b1}}}) begin
            return {FW{1'b1}};
        end
        return v[FW-1:0];
    endfunction

    // Configuration registers
    logic [CFG_DATA_W-1:0] r_hdr_to;
    logic [CFG_DATA_W-1:0] r_pay_to;
    logic [CAP_W-1:0]      r_cap;

    // Parser state
    t_phase          r_phase, n_phase;
    logic [2:0]      r_pos, n_pos;
    logic [FW-1:0]   r_f1, n_f1;
    logic [FW-1:0]   r_f2, n_f2;
    logic            r_stop, n_stop;
    logic            r_comma, n_comma;
    logic [FW-1:0]   r_cnt, n_cnt;
    logic [FW-1:0]   r_tgt, n_tgt;
    logic [31:0]     r_ticks, n_ticks;

    // Result register
    logic              r_out_valid;
    logic [KIND_W-1:0] r_kind;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic [DLEN_W-1:0] r_dlen;
    logic [ID_W-1:0]   r_id;
    logic              r_hasid;

    // Combinational result
    logic              w_acc;
    logic              w_emit;
    logic [KIND_W-1:0] w_kind;
    logic [BYTE_W-1:0] w_byte;
    logic              w_last;
    logic [DLEN_W-1:0] w_dlen;
    logic [ID_W-1:0]   w_id;
    logic              w_hasid;

    logic [FW-1:0]     w_len;
    logic [CW-1:0]     w_len_ext;
    logic [CAP_W-1:0]  w_cap_eff;
    logic [CW-1:0]     w_cap_ext;
    logic [FW-1:0]     w_cnt_inc;
    logic [ID_W-1:0]   w_cur_id;
    logic              w_is_digit;
    logic [3:0]        w_digit;

    // Take a request whenever the result register is free or being drained
    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign w_acc      = i_rx.valid && i_rx.ready;

    assign w_len      = r_comma ? r_f2 : r_f1;
    assign w_len_ext  = CW'(w_len);
    assign w_cap_eff  = (r_cap == '0) ? CAP_W'(1) : r_cap;
    assign w_cap_ext  = CW'(w_cap_eff);
    assign w_cnt_inc  = r_cnt + FW'(1);
    assign w_cur_id   = r_comma ? r_f1[ID_W-1:0] : '0;
    assign w_is_digit = (i_rx.rx_byte >= CH_ZERO) && (i_rx.rx_byte <= CH_NINE);
    assign w_digit    = 4'(i_rx.rx_byte - CH_ZERO);

    // Next state and result for the accepted request
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_f1    = r_f1;
        n_f2    = r_f2;
        n_stop  = r_stop;
        n_comma = r_comma;
        n_cnt   = r_cnt;
        n_tgt   = r_tgt;
        n_ticks = r_ticks;
        w_emit  = 1'b0;
        w_kind  = RK_BYTE;
        w_byte  = '0;
        w_last  = 1'b0;
        w_dlen  = '0;
        w_id    = '0;
        w_hasid = 1'b0;

        if (w_acc) begin
            case (i_rx.opcode)
                OP_BYTE: begin
                    case (r_phase)
                        PH_HUNT: begin
                            // Advance on a pattern match, else restart (a plus sign counts as the first match)
                            if (r_pos < HDR_LEN && i_rx.rx_byte == hdr_char(r_pos)) begin
                                n_pos = r_pos + 3'd1;
                            end else begin
                                n_pos = (i_rx.rx_byte == CH_PLUS) ? 3'd1 : 3'd0;
                            end
                            if (n_pos >= HDR_LEN) begin
                                n_phase = PH_HEAD;
                            end
                        end
                        PH_HEAD: begin
                            if (i_rx.rx_byte == CH_COLON) begin
                                // Check the header fields
                                if (r_comma && r_f1 > FW'(MAX_ID)) begin
                                    n_phase = PH_IDLE;
                                    w_emit  = 1'b1;
                                    w_kind  = RK_BAD_ID;
                                    w_last  = 1'b1;
                                    w_hasid = 1'b1;
                                end else if (w_len == '0) begin
                                    n_phase = PH_IDLE;
                                    w_emit  = 1'b1;
                                    w_kind  = RK_BAD_LEN;
                                    w_last  = 1'b1;
                                    w_id    = w_cur_id;
                                    w_hasid = r_comma;
                                end else begin
                                    n_tgt   = (w_len_ext < w_cap_ext) ? w_len
                                                                      : w_cap_ext[FW-1:0];
                                    n_cnt   = '0;
                                    n_ticks = '0;
                                    n_phase = PH_DATA;
                                end
                            end else if (i_rx.rx_byte == CH_COMMA && !r_comma) begin
                                n_comma = 1'b1;
                                n_stop  = 1'b0;
                            end else if (w_is_digit && !r_stop) begin
                                if (r_comma) begin
                                    n_f2 = add_digit(r_f2, w_digit);
                                end else begin
                                    n_f1 = add_digit(r_f1, w_digit);
                                end
                            end else begin
                                n_stop = 1'b1;
                            end
                        end
                        PH_DATA: begin
                            // Deliver one payload byte
                            n_cnt   = w_cnt_inc;
                            w_emit  = 1'b1;
                            w_kind  = RK_BYTE;
                            w_byte  = i_rx.rx_byte;
                            w_last  = (w_cnt_inc >= r_tgt);
                            w_dlen  = w_len_ext[DLEN_W-1:0];
                            w_id    = w_cur_id;
                            w_hasid = r_comma;
                            if (w_last) begin
                                n_phase = (w_len > r_tgt) ? PH_SKIP : PH_IDLE;
                            end
                        end
                        PH_SKIP: begin
                            // Drop excess payload
                            n_cnt = w_cnt_inc;
                            if (w_cnt_inc >= w_len) begin
                                n_phase = PH_IDLE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                OP_TICK: begin
                    if (r_phase != PH_IDLE) begin
                        if (r_ticks != '1) begin
                            n_ticks = r_ticks + 32'd1;
                        end
                        if (r_phase == PH_HUNT || r_phase == PH_HEAD) begin
                            if (n_ticks >= r_hdr_to) begin
                                n_phase = PH_IDLE;
                                w_emit  = 1'b1;
                                w_kind  = RK_HDR_TO;
                                w_last  = 1'b1;
                            end
                        end else if (n_ticks >= r_pay_to) begin
                            n_phase = PH_IDLE;
                            if (r_phase == PH_DATA) begin
                                w_emit  = 1'b1;
                                w_kind  = RK_PAY_TO;
                                w_last  = 1'b1;
                                w_dlen  = w_len_ext[DLEN_W-1:0];
                                w_id    = w_cur_id;
                                w_hasid = r_comma;
                            end
                        end
                    end
                end
                OP_ARM: begin
                    // Drop any receive and restart the hunt
                    n_phase = PH_HUNT;
                    n_pos   = '0;
                    n_f1    = '0;
                    n_f2    = '0;
                    n_stop  = 1'b0;
                    n_comma = 1'b0;
                    n_cnt   = '0;
                    n_tgt   = '0;
                    n_ticks = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // State, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_to    <= HDR_TO_RST;
            r_pay_to    <= PAY_TO_RST;
            r_cap       <= CAP_RST;
            r_phase     <= PH_IDLE;
            r_pos       <= '0;
            r_f1        <= '0;
            r_f2        <= '0;
            r_stop      <= 1'b0;
            r_comma     <= 1'b0;
            r_cnt       <= '0;
            r_tgt       <= '0;
            r_ticks     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HDR_TO: r_hdr_to <= i_cfg_data;
                    CFG_PAY_TO: r_pay_to <= i_cfg_data;
                    CFG_CAP:    r_cap    <= i_cfg_data[CAP_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_f1    <= n_f1;
            r_f2    <= n_f2;
            r_stop  <= n_stop;
            r_comma <= n_comma;
            r_cnt   <= n_cnt;
            r_tgt   <= n_tgt;
            r_ticks <= n_ticks;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_emit) begin
            r_kind  <= w_kind;
            r_byte  <= w_byte;
            r_last  <= w_last;
            r_dlen  <= w_dlen;
            r_id    <= w_id;
            r_hasid <= w_hasid;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.result_kind     = r_kind;
    assign o_res.payload_byte    = r_byte;
    assign o_res.is_last         = r_last;
    assign o_res.declared_length = r_dlen;
    assign o_res.conn_id         = r_id;
    assign o_res.has_id          = r_hasid;

    // Idle requests never produce a result
    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> !w_emit)
        else $error("result produced while idle");

    // Only payload bytes may be non-final
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.is_last) |-> (o_res.result_kind == RK_BYTE))
        else $error("error result without last flag");

    // Delivery count stays below the target while delivering
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_cnt < r_tgt))
        else $error("payload count reached target in data phase");

    // Header match position stays inside the pattern while hunting
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HUNT) |-> (r_pos < HDR_LEN))
        else $error("header match position out of range");

    // Arm always restarts the hunt
    a_arm_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_rx.opcode == OP_ARM) |=> (r_phase == PH_HUNT))
        else $error("arm did not restart the hunt");

endmodule
